[hdl/nng_pkg.sv]
// Package with the constants, types and helper functions of the nearest-node graph table.
`default_nettype none

package nng_pkg;

    localparam int MAX_NODES  = 32;
    localparam int MAX_LINKS  = 4;
    localparam int COORD_BITS = 16;

    localparam int ID_W      = 5;
    localparam int CNT_W     = 3;
    localparam int IN_LINKS  = 4;
    localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int LINK_IW   = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
    localparam int LINK_CAP  = (MAX_LINKS < IN_LINKS) ? MAX_LINKS : IN_LINKS;
    localparam int SQ_W      = 2 * COORD_BITS;
    localparam int DIST_W    = SQ_W + 1;
    localparam int STEP_MAX  = (MAX_NODES - 1 > MAX_LINKS + 1) ? MAX_NODES - 1 : MAX_LINKS + 1;
    localparam int STEP_W    = $clog2(STEP_MAX + 1);

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_FIND    = 2'd1,
        REQ_NEIGH   = 2'd2,
        REQ_NEAREST = 2'd3
    } req_code_t;

    typedef struct packed {
        req_code_t                     req_type;
        logic [ID_W-1:0]               node_id;
        logic signed [COORD_BITS-1:0]  pos_x;
        logic signed [COORD_BITS-1:0]  pos_y;
        logic [CNT_W-1:0]              link_count;
        logic [ID_W-1:0]               link_a;
        logic [ID_W-1:0]               link_b;
        logic [ID_W-1:0]               link_c;
        logic [ID_W-1:0]               link_d;
    } req_t;

    typedef struct packed {
        logic                          found;
        logic [ID_W-1:0]               result_id;
        logic signed [COORD_BITS-1:0]  result_x;
        logic signed [COORD_BITS-1:0]  result_y;
    } rsp_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]       x;
        logic signed [COORD_BITS-1:0]       y;
        logic [CNT_W-1:0]                   cnt;
        logic [MAX_LINKS-1:0][ID_W-1:0]     links;
    } node_t;

    localparam int NODE_W = $bits(node_t);

    function automatic logic in_range(input logic [ID_W-1:0] v);
        return 32'(v) < MAX_NODES;
    endfunction

    function automatic logic [IDX_W-1:0] to_idx(input logic [ID_W-1:0] v);
        return IDX_W'(32'(v));
    endfunction

endpackage

`default_nettype wire

[hdl/nng_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module nng_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[hdl/nearest_node_graph_table_unit.sv]
// Top level of the nearest-node graph table: node memory, scan sequencer and distance pipeline.
// A load transaction writes its slot and gives its result through the done state, and the next
// one is accepted once that result is out. Find and nearest-node transactions scan every slot
// through the node memory read port, one per cycle, and drain the distance pipeline before
// giving their result. A neighbor transaction reads the current node and then its links.
// One transaction is in work at a time; reset clears every slot valid mark at once.
`default_nettype none

module nearest_node_graph_table_unit
    import nng_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    logic [STEP_W-1:0]              step_reg, step_next;
    req_code_t                      op_reg, op_next;
    logic [ID_W-1:0]                id_reg, id_next;
    logic signed [COORD_BITS-1:0]   px_reg, px_next;
    logic signed [COORD_BITS-1:0]   py_reg, py_next;
    logic                           cur_ok_reg, cur_ok_next;
    logic [MAX_LINKS-1:0][ID_W-1:0] links_reg, links_next;
    logic [CNT_W-1:0]               n_reg, n_next;
    logic [MAX_NODES-1:0]           slot_valid_reg, slot_valid_next;

    logic                           found_reg, found_next;
    logic [ID_W-1:0]                rid_reg, rid_next;
    logic signed [COORD_BITS-1:0]   rx_reg, rx_next;
    logic signed [COORD_BITS-1:0]   ry_reg, ry_next;
    logic [DIST_W-1:0]              best_reg, best_next;

    logic                           rsp_valid_reg, rsp_valid_next;
    rsp_t                           rsp_reg, rsp_next;

    logic                           accept;
    logic                           wr_en;
    node_t                          wr_node;
    logic [NODE_W-1:0]              rd_word;
    node_t                          rd_node;
    logic [IDX_W-1:0]               rd_addr;
    logic                           iss_valid;
    logic                           iss_first;
    logic [ID_W-1:0]                in_links [IN_LINKS];
    logic [CNT_W-1:0]               in_cnt;

    logic                           a_valid_reg, a_first_reg;
    logic [IDX_W-1:0]               a_id_reg;
    logic                           b_valid_reg, b_first_reg, b_eq_reg;
    logic [IDX_W-1:0]               b_id_reg;
    logic [COORD_BITS-1:0]          b_dx_reg, b_dy_reg;
    logic signed [COORD_BITS-1:0]   b_x_reg, b_y_reg;
    logic                           c_valid_reg, c_first_reg, c_eq_reg;
    logic [IDX_W-1:0]               c_id_reg;
    logic [SQ_W-1:0]                c_sqx_reg, c_sqy_reg;
    logic signed [COORD_BITS-1:0]   c_x_reg, c_y_reg;

    logic signed [COORD_BITS:0]     diff_x, diff_y;
    logic [COORD_BITS:0]            mag_x, mag_y;
    logic [DIST_W-1:0]              dist_sum;
    logic                           dist_less;
    logic [STEP_W-1:0]              last_step;

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && (state_reg == S_IDLE);
    assign wr_en     = accept && (req.req_type == REQ_LOAD) && in_range(req.node_id);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rd_node   = node_t'(rd_word);

    assign in_links[0] = req.link_a;
    assign in_links[1] = req.link_b;
    assign in_links[2] = req.link_c;
    assign in_links[3] = req.link_d;
    assign in_cnt = (req.link_count > CNT_W'(LINK_CAP)) ? CNT_W'(LINK_CAP) : req.link_count;

    always_comb
    begin
        wr_node.x     = req.pos_x;
        wr_node.y     = req.pos_y;
        wr_node.cnt   = in_cnt;
        wr_node.links = '0;
        for (int k = 0; k < MAX_LINKS; k++)
        begin
            if (k < IN_LINKS && k < int'(in_cnt))
            begin
                wr_node.links[k] = in_links[k];
            end
        end
    end

    nng_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (to_idx(req.node_id)),
        .wr_data (NODE_W'(wr_node)),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    always_comb
    begin
        logic [ID_W-1:0] nb;
        int              k;
        nb        = '0;
        k         = 0;
        iss_valid = 1'b0;
        iss_first = 1'b0;
        rd_addr   = '0;
        if (state_reg == S_SCAN)
        begin
            if (op_reg == REQ_NEIGH)
            begin
                if (step_reg == '0)
                begin
                    rd_addr   = to_idx(id_reg);
                    iss_valid = cur_ok_reg;
                    iss_first = 1'b1;
                end
                else if (int'(step_reg) >= 2)
                begin
                    k         = int'(step_reg) - 2;
                    nb        = links_reg[LINK_IW'(k)];
                    rd_addr   = to_idx(nb);
                    iss_valid = cur_ok_reg && (k < int'(n_reg)) && in_range(nb)
                                && slot_valid_reg[to_idx(nb)];
                end
            end
            else
            begin
                rd_addr   = step_reg[IDX_W-1:0];
                iss_valid = slot_valid_reg[step_reg[IDX_W-1:0]];
            end
        end
    end

    assign diff_x = {rd_node.x[COORD_BITS-1], rd_node.x} - {px_reg[COORD_BITS-1], px_reg};
    assign diff_y = {rd_node.y[COORD_BITS-1], rd_node.y} - {py_reg[COORD_BITS-1], py_reg};
    assign mag_x  = diff_x[COORD_BITS] ? (COORD_BITS + 1)'(0) - diff_x : diff_x;
    assign mag_y  = diff_y[COORD_BITS] ? (COORD_BITS + 1)'(0) - diff_y : diff_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= iss_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_first_reg <= iss_first;
        a_id_reg    <= rd_addr;
        b_first_reg <= a_first_reg;
        b_id_reg    <= a_id_reg;
        b_eq_reg    <= (rd_node.x == px_reg) && (rd_node.y == py_reg);
        b_dx_reg    <= mag_x[COORD_BITS-1:0];
        b_dy_reg    <= mag_y[COORD_BITS-1:0];
        b_x_reg     <= rd_node.x;
        b_y_reg     <= rd_node.y;
        c_first_reg <= b_first_reg;
        c_id_reg    <= b_id_reg;
        c_eq_reg    <= b_eq_reg;
        c_sqx_reg   <= SQ_W'(b_dx_reg) * SQ_W'(b_dx_reg);
        c_sqy_reg   <= SQ_W'(b_dy_reg) * SQ_W'(b_dy_reg);
        c_x_reg     <= b_x_reg;
        c_y_reg     <= b_y_reg;
    end

    assign dist_sum  = DIST_W'(c_sqx_reg) + DIST_W'(c_sqy_reg);
    assign dist_less = dist_sum < best_reg;
    assign last_step = (op_reg == REQ_NEIGH) ? STEP_W'(MAX_LINKS + 1) : STEP_W'(MAX_NODES - 1);

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        cur_ok_next     = cur_ok_reg;
        links_next      = links_reg;
        n_next          = n_reg;
        slot_valid_next = slot_valid_reg;
        found_next      = found_reg;
        rid_next        = rid_reg;
        rx_next         = rx_reg;
        ry_next         = ry_reg;
        best_next       = best_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        if (c_valid_reg)
        begin
            unique case (op_reg)
                REQ_FIND:
                begin
                    if (c_eq_reg && !found_reg)
                    begin
                        found_next = 1'b1;
                        rid_next   = ID_W'(32'(c_id_reg));
                    end
                end
                REQ_NEAREST:
                begin
                    if (!found_reg || dist_less)
                    begin
                        found_next = 1'b1;
                        best_next  = dist_sum;
                        rid_next   = ID_W'(32'(c_id_reg));
                    end
                end
                REQ_NEIGH:
                begin
                    if (c_first_reg)
                    begin
                        found_next = 1'b1;
                        best_next  = dist_sum;
                    end
                    else if (dist_less)
                    begin
                        best_next = dist_sum;
                        rid_next  = ID_W'(32'(c_id_reg));
                        rx_next   = c_x_reg;
                        ry_next   = c_y_reg;
                    end
                end
                REQ_LOAD:
                begin
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req.req_type;
                    id_next     = req.node_id;
                    px_next     = req.pos_x;
                    py_next     = req.pos_y;
                    cur_ok_next = in_range(req.node_id) && slot_valid_reg[to_idx(req.node_id)];
                    step_next   = '0;
                    found_next  = 1'b0;
                    rid_next    = '0;
                    rx_next     = '0;
                    ry_next     = '0;
                    best_next   = '0;
                    if (req.req_type == REQ_LOAD)
                    begin
                        if (in_range(req.node_id))
                        begin
                            slot_valid_next[to_idx(req.node_id)] = 1'b1;
                            found_next = 1'b1;
                            rid_next   = req.node_id;
                        end
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (op_reg == REQ_NEIGH && step_reg == STEP_W'(1))
                begin
                    links_next = rd_node.links;
                    n_next     = rd_node.cnt;
                end
                if (step_reg == last_step)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (!a_valid_reg && !b_valid_reg && !c_valid_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.found     = found_reg;
                    rsp_next.result_id = rid_reg;
                    rsp_next.result_x  = rx_reg;
                    rsp_next.result_y  = ry_reg;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            slot_valid_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            slot_valid_reg <= slot_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        id_reg     <= id_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        cur_ok_reg <= cur_ok_next;
        links_reg  <= links_next;
        n_reg      <= n_next;
        found_reg  <= found_next;
        rid_reg    <= rid_next;
        rx_reg     <= rx_next;
        ry_reg     <= ry_next;
        best_reg   <= best_next;
        rsp_reg    <= rsp_next;
    end

`ifndef SYNTH
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!a_valid_reg && !b_valid_reg && !c_valid_reg))
        else $error("Distance pipeline holds work while the sequencer is idle.");

    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        c_valid_reg |-> (state_reg == S_SCAN || state_reg == S_DRAIN))
        else $error("Distance pipeline updates the result outside a scan.");

    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.req_type == REQ_LOAD && in_range(req.node_id))
        |=> (state_reg == S_DONE && found_reg && slot_valid_reg[rid_reg[IDX_W-1:0]]))
        else $error("Load transaction did not mark its slot valid.");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_reg.found)
        |-> (rsp_reg.result_id == '0 && rsp_reg.result_x == '0 && rsp_reg.result_y == '0))
        else $error("Result without found flag carries nonzero fields.");
`endif

endmodule

`default_nettype wire
